// File: rtl/nss_pkg.sv
`default_nettype none
package nss_pkg;

  localparam int PATTERN_DEPTH = 64;
  localparam int PAT_AW = $clog2(PATTERN_DEPTH);
  localparam int LEN_W = $clog2(PATTERN_DEPTH + 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(PATTERN_DEPTH);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4);

  localparam int CNT_W = 22;
  localparam int ALU_W = 23;
  localparam int CFG_W = 20;

  localparam int MOD_STEPS = 8;
  localparam int MOD_CW = $clog2(MOD_STEPS);

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_LEARN   = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  localparam logic [1:0] DIR_UP     = 2'd0;
  localparam logic [1:0] DIR_DOWN   = 2'd1;
  localparam logic [1:0] DIR_UPDOWN = 2'd2;
  localparam logic [1:0] DIR_RANDOM = 2'd3;

  localparam logic [2:0] CFG_DIRECTION   = 3'd0;
  localparam logic [2:0] CFG_OCTAVE_SPAN = 3'd1;
  localparam logic [2:0] CFG_STEP_PERIOD = 3'd2;
  localparam logic [2:0] CFG_RETRIGGER   = 3'd3;

  localparam logic [19:0] PERIOD_RESET = 20'd400000;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  localparam logic signed [ALU_W-1:0] CNT_FLOOR    = ALU_W'(-(2 ** (CNT_W - 1)));
  localparam logic signed [ALU_W-1:0] STEP_FINE    = ALU_W'(12);
  localparam logic signed [ALU_W-1:0] STEP_COARSE  = ALU_W'(48);
  localparam logic signed [ALU_W-1:0] KEY_LIMIT    = ALU_W'(128);
  localparam logic signed [ALU_W-1:0] FOLD_NEG_FAR = ALU_W'(-36);
  localparam logic signed [ALU_W-1:0] FOLD_POS_FAR = ALU_W'(176);

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] sample_count;
    logic [6:0]  base_key;
  } cmd_t;

  typedef struct packed {
    logic [6:0] key_out;
    logic       retrigger;
    logic [6:0] position;
    logic [3:0] octave_now;
  } res_t;

  typedef struct packed {
    logic [1:0]  direction;
    logic [3:0]  octave_span;
    logic [19:0] step_period;
    logic        retrigger_enable;
  } cfg_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic              we;
    logic [PAT_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK_ADD,
    ST_ADVANCE,
    ST_RND_POS,
    ST_RND_OCT,
    ST_MOD,
    ST_READ,
    ST_SUM_OFF,
    ST_SUM_OCT,
    ST_FOLD,
    ST_DONE
  } state_t;

  function automatic logic [7:0] pat_reset_val(input logic [PAT_AW-1:0] idx);
    logic [7:0] v;
    case (int'(idx))
      0: v = 8'd0;
      1: v = 8'd4;
      2: v = 8'd7;
      3: v = 8'd12;
      4: v = 8'd16;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // Galois form, shifting right
  function automatic logic [15:0] lfsr_step(input logic [15:0] l);
    return (l >> 1) ^ (l[0] ? LFSR_TAPS : 16'h0000);
  endfunction

endpackage
`default_nettype wire

// File: rtl/nss_alu.sv
`default_nettype none
module nss_alu (
  input  nss_pkg::alu_req_t                req,
  output logic signed [nss_pkg::ALU_W-1:0] y
);

  always_comb begin
    if (req.sub) begin
      y = $signed(req.a) - $signed(req.b);
    end else begin
      y = $signed(req.a) + $signed(req.b);
    end
  end

endmodule
`default_nettype wire

// File: rtl/nss_pattern_ram.sv
`default_nettype none
module nss_pattern_ram (
  input  logic                       clk,
  input  logic                       rst,
  input  nss_pkg::ram_wr_t           wr,
  input  logic [nss_pkg::PAT_AW-1:0] raddr,
  output logic [7:0]                 rdata
);

  logic [7:0] mem [nss_pkg::PATTERN_DEPTH];
  logic [nss_pkg::PATTERN_DEPTH-1:0] written;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.we) begin
      written[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // entries not yet written read back their power-up pattern
  always_ff @(posedge clk) begin
    if (written[raddr]) begin
      rdata <= mem[raddr];
    end else begin
      rdata <= nss_pkg::pat_reset_val(raddr);
    end
  end

endmodule
`default_nettype wire

// File: rtl/nss_core.sv
`default_nettype none
module nss_core (
  input  logic          clk,
  input  logic          rst,
  input  nss_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  nss_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output nss_pkg::res_t res
);

  nss_pkg::state_t state, state_next;

  // latched command
  logic [1:0]  op;
  logic [11:0] samples;
  logic [6:0]  key;
  logic        trig;

  // sequencer state
  logic [nss_pkg::LEN_W-1:0]        length;
  logic [6:0]                       ref_key;
  logic signed [nss_pkg::CNT_W-1:0] counter;
  logic [nss_pkg::PAT_AW-1:0]       pos;
  logic [3:0]                       oct;
  logic                             down;
  logic [15:0]                      lfsr;

  logic signed [nss_pkg::ALU_W-1:0] acc;

  // remainder unit
  logic [nss_pkg::PAT_AW-1:0] mod_rem;
  logic [7:0]                 mod_div;
  logic [nss_pkg::MOD_CW-1:0] mod_cnt;
  logic                       mod_oct;

  nss_pkg::alu_req_t                alu_req;
  logic signed [nss_pkg::ALU_W-1:0] y;
  nss_pkg::ram_wr_t                 ram_wr;
  logic [7:0]                       rdata;

  logic [3:0]                       span_eff;
  logic [nss_pkg::PAT_AW-1:0]       last_pos;
  logic                             at_end;
  logic [4:0]                       oct_inc;
  logic                             oct_wrap;
  logic [6:0]                       ref_eff;
  logic signed [nss_pkg::CNT_W-1:0] tick_sat;
  logic                             tick_expire;
  logic [nss_pkg::PAT_AW:0]         trial;
  logic [nss_pkg::PAT_AW-1:0]       rem_new;
  logic                             mod_last;
  logic [15:0]                      lfsr_nxt;
  logic [7:0]                       oct12;
  logic                             acc_in_range;
  logic                             slot_free;

  nss_alu u_alu (
    .req (alu_req),
    .y   (y)
  );

  nss_pattern_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .wr    (ram_wr),
    .raddr (pos),
    .rdata (rdata)
  );

  always_comb begin
    span_eff = (cfg.octave_span == 4'd0) ? 4'd1 : cfg.octave_span;
    last_pos = (length != '0) ? nss_pkg::PAT_AW'(length - nss_pkg::LEN_W'(1)) : '0;
    at_end   = (nss_pkg::LEN_W'(pos) + nss_pkg::LEN_W'(1)) >= length;
    oct_inc  = {1'b0, oct} + 5'd1;
    oct_wrap = oct_inc > {1'b0, span_eff};
    ref_eff  = (length == '0) ? key : ref_key;
    lfsr_nxt = nss_pkg::lfsr_step(lfsr);
    oct12    = 8'({oct, 3'b000}) + 8'({oct, 2'b00});
    trial    = {mod_rem, mod_div[7]};
    rem_new  = y[nss_pkg::ALU_W-1] ? trial[nss_pkg::PAT_AW-1:0] : y[nss_pkg::PAT_AW-1:0];
    mod_last = mod_cnt == nss_pkg::MOD_CW'(nss_pkg::MOD_STEPS - 1);
    acc_in_range = !acc[nss_pkg::ALU_W-1] && (acc < nss_pkg::KEY_LIMIT);
    slot_free = !res_valid || !res_stall;
    if (y < nss_pkg::CNT_FLOOR) begin
      tick_sat = nss_pkg::CNT_FLOOR[nss_pkg::CNT_W-1:0];
    end else begin
      tick_sat = y[nss_pkg::CNT_W-1:0];
    end
    tick_expire = tick_sat[nss_pkg::CNT_W-1] || (tick_sat == '0);
  end

  always_comb begin
    state_next = state;
    case (state)
      nss_pkg::ST_IDLE: begin
        if (cmd_valid) state_next = nss_pkg::ST_EXEC;
      end
      nss_pkg::ST_EXEC: begin
        if (op == nss_pkg::OP_TICK && tick_expire) begin
          state_next = nss_pkg::ST_TICK_ADD;
        end else begin
          state_next = nss_pkg::ST_READ;
        end
      end
      nss_pkg::ST_TICK_ADD: begin
        state_next = (cfg.direction == nss_pkg::DIR_RANDOM) ? nss_pkg::ST_RND_POS
                                                            : nss_pkg::ST_ADVANCE;
      end
      nss_pkg::ST_ADVANCE: state_next = nss_pkg::ST_READ;
      nss_pkg::ST_RND_POS: begin
        state_next = (length == '0) ? nss_pkg::ST_RND_OCT : nss_pkg::ST_MOD;
      end
      nss_pkg::ST_RND_OCT: state_next = nss_pkg::ST_MOD;
      nss_pkg::ST_MOD: begin
        if (mod_last) state_next = mod_oct ? nss_pkg::ST_READ : nss_pkg::ST_RND_OCT;
      end
      nss_pkg::ST_READ:    state_next = nss_pkg::ST_SUM_OFF;
      nss_pkg::ST_SUM_OFF: state_next = nss_pkg::ST_SUM_OCT;
      nss_pkg::ST_SUM_OCT: state_next = nss_pkg::ST_FOLD;
      nss_pkg::ST_FOLD: begin
        if (acc_in_range) state_next = nss_pkg::ST_DONE;
      end
      nss_pkg::ST_DONE: begin
        if (slot_free) state_next = nss_pkg::ST_IDLE;
      end
      default: state_next = nss_pkg::ST_IDLE;
    endcase
  end

  // shared adder operands and pattern write port
  always_comb begin
    alu_req     = '0;
    ram_wr.we   = 1'b0;
    ram_wr.addr = length[nss_pkg::PAT_AW-1:0];
    ram_wr.data = y[7:0];
    cmd_stall   = state != nss_pkg::ST_IDLE;
    case (state)
      nss_pkg::ST_EXEC: begin
        alu_req.sub = 1'b1;
        if (op == nss_pkg::OP_TICK) begin
          alu_req.a = nss_pkg::ALU_W'(counter);
          alu_req.b = nss_pkg::ALU_W'(samples);
        end else begin
          alu_req.a = nss_pkg::ALU_W'(key);
          alu_req.b = nss_pkg::ALU_W'(ref_eff);
        end
        ram_wr.we = (op == nss_pkg::OP_LEARN) && (length < nss_pkg::LEN_FULL);
      end
      nss_pkg::ST_TICK_ADD: begin
        alu_req.a = nss_pkg::ALU_W'(counter);
        alu_req.b = nss_pkg::ALU_W'(cfg.step_period);
      end
      nss_pkg::ST_MOD: begin
        alu_req.sub = 1'b1;
        alu_req.a   = nss_pkg::ALU_W'(trial);
        alu_req.b   = mod_oct ? nss_pkg::ALU_W'(span_eff) : nss_pkg::ALU_W'(length);
      end
      nss_pkg::ST_SUM_OFF: begin
        alu_req.a = nss_pkg::ALU_W'(key);
        alu_req.b = (length == '0) ? '0 : nss_pkg::ALU_W'($signed(rdata));
      end
      nss_pkg::ST_SUM_OCT: begin
        alu_req.a = acc;
        alu_req.b = nss_pkg::ALU_W'(oct12);
      end
      nss_pkg::ST_FOLD: begin
        alu_req.a = acc;
        if (acc[nss_pkg::ALU_W-1]) begin
          alu_req.b = (acc < nss_pkg::FOLD_NEG_FAR) ? nss_pkg::STEP_COARSE
                                                     : nss_pkg::STEP_FINE;
        end else begin
          alu_req.sub = 1'b1;
          alu_req.b = (acc >= nss_pkg::FOLD_POS_FAR) ? nss_pkg::STEP_COARSE
                                                      : nss_pkg::STEP_FINE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= nss_pkg::LEN_RESET;
      ref_key   <= '0;
      counter   <= '0;
      pos       <= '0;
      oct       <= 4'd1;
      down      <= 1'b0;
      lfsr      <= nss_pkg::LFSR_SEED;
      res_valid <= 1'b0;
    end else begin
      if (state == nss_pkg::ST_DONE && slot_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        nss_pkg::ST_EXEC: begin
          case (op)
            nss_pkg::OP_TICK: counter <= tick_sat;
            nss_pkg::OP_LEARN: begin
              if (length < nss_pkg::LEN_FULL) begin
                if (length == '0) ref_key <= key;
                length <= length + nss_pkg::LEN_W'(1);
              end
            end
            nss_pkg::OP_CLEAR: begin
              length <= '0;
              pos    <= '0;
            end
            nss_pkg::OP_RESTART: begin
              counter <= nss_pkg::CNT_W'(cfg.step_period);
              if (cfg.direction == nss_pkg::DIR_DOWN) begin
                pos  <= last_pos;
                oct  <= span_eff;
                down <= 1'b1;
              end else begin
                pos  <= '0;
                oct  <= 4'd1;
                down <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        nss_pkg::ST_TICK_ADD: counter <= y[nss_pkg::CNT_W-1:0];
        nss_pkg::ST_ADVANCE: begin
          case (cfg.direction)
            nss_pkg::DIR_UP: begin
              if (at_end) begin
                pos <= '0;
                oct <= oct_wrap ? 4'd1 : oct_inc[3:0];
              end else begin
                pos <= pos + nss_pkg::PAT_AW'(1);
              end
            end
            nss_pkg::DIR_DOWN: begin
              if (pos == '0) begin
                pos <= last_pos;
                oct <= (oct <= 4'd1) ? span_eff : oct - 4'd1;
              end else begin
                pos <= pos - nss_pkg::PAT_AW'(1);
              end
            end
            nss_pkg::DIR_UPDOWN: begin
              if (down) begin
                if (pos == '0) begin
                  if (oct <= 4'd1) begin
                    pos  <= '0;
                    down <= 1'b0;
                    oct  <= 4'd1;
                  end else begin
                    oct <= oct - 4'd1;
                    pos <= last_pos;
                  end
                end else begin
                  pos <= pos - nss_pkg::PAT_AW'(1);
                end
              end else if (at_end) begin
                if (oct_wrap) begin
                  pos  <= last_pos;
                  down <= 1'b1;
                  oct  <= span_eff;
                end else begin
                  oct <= oct_inc[3:0];
                  pos <= '0;
                end
              end else begin
                pos <= pos + nss_pkg::PAT_AW'(1);
              end
            end
            default: begin
            end
          endcase
        end
        nss_pkg::ST_RND_POS: begin
          lfsr <= lfsr_nxt;
          if (length == '0) pos <= '0;
        end
        nss_pkg::ST_RND_OCT: lfsr <= lfsr_nxt;
        nss_pkg::ST_MOD: begin
          if (mod_last) begin
            if (mod_oct) begin
              oct <= 4'(rem_new) + 4'd1;
            end else begin
              pos <= rem_new;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      nss_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          op      <= cmd.opcode;
          samples <= cmd.sample_count;
          key     <= cmd.base_key;
          trig    <= 1'b0;
        end
      end
      nss_pkg::ST_TICK_ADD: trig <= cfg.retrigger_enable;
      nss_pkg::ST_RND_POS: begin
        mod_div <= lfsr_nxt[7:0];
        mod_rem <= '0;
        mod_cnt <= '0;
        mod_oct <= 1'b0;
      end
      nss_pkg::ST_RND_OCT: begin
        mod_div <= {6'b000000, lfsr_nxt[1:0]};
        mod_rem <= '0;
        mod_cnt <= '0;
        mod_oct <= 1'b1;
      end
      nss_pkg::ST_MOD: begin
        mod_rem <= rem_new;
        mod_div <= {mod_div[6:0], 1'b0};
        mod_cnt <= mod_cnt + nss_pkg::MOD_CW'(1);
      end
      nss_pkg::ST_SUM_OFF: acc <= y;
      nss_pkg::ST_SUM_OCT: acc <= y;
      nss_pkg::ST_FOLD: begin
        if (!acc_in_range) acc <= y;
      end
      nss_pkg::ST_DONE: begin
        if (slot_free) begin
          res.key_out    <= acc[6:0];
          res.retrigger  <= trig;
          res.position   <= 7'(pos);
          res.octave_now <= oct;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/note_step_sequencer_top.sv
// Learn, clear, restart and plain ticks go from accept through EXEC, READ, SUM_OFF,
// SUM_OCT and the key-folding steps to DONE; a step advance adds TICK_ADD and ADVANCE, a
// random step adds TICK_ADD and two 8-step remainder passes (one on an empty pattern)
// through the shared adder.
// One item at a time: the next beat is taken only after the previous result is
// loaded into the output register.
// Sync reset restores the power-up pattern (0,4,7,12) and register defaults.
`default_nettype none
module note_step_sequencer_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [nss_pkg::CFG_W-1:0] cfg_data,
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  nss_pkg::cmd_t             cmd,
  output logic                      res_valid,
  input  logic                      res_stall,
  output nss_pkg::res_t             res
);

  nss_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction        <= nss_pkg::DIR_UPDOWN;
      cfg.octave_span      <= 4'd1;
      cfg.step_period      <= nss_pkg::PERIOD_RESET;
      cfg.retrigger_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        nss_pkg::CFG_DIRECTION:   cfg.direction        <= cfg_data[1:0];
        nss_pkg::CFG_OCTAVE_SPAN: cfg.octave_span      <= cfg_data[3:0];
        nss_pkg::CFG_STEP_PERIOD: cfg.step_period      <= cfg_data[19:0];
        nss_pkg::CFG_RETRIGGER:   cfg.retrigger_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  nss_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
`default_nettype wire

// File: rtl/nss_checker.sv
`default_nettype none
module nss_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      cmd_valid,
  input wire logic                      cmd_stall,
  input wire logic                      res_valid,
  input wire logic                      res_stall,
  input wire nss_pkg::res_t             res
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("second beat taken while an item is in work");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> !$rose(res_valid))
    else $error("result appeared one cycle after accept");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.octave_now != 4'd0) &&
                  (int'(res.position) < nss_pkg::PATTERN_DEPTH))
    else $error("octave or position out of range");

endmodule

bind note_step_sequencer_top nss_checker u_nss_checker (.*);
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import nss_pkg::*;

  localparam int OCTAVE_KEYS = 12;
  localparam int KEY_RANGE = 128;
  localparam int COUNT_FLOOR = -(1 << 21);
  localparam logic [15:0] RAND_SEED = 16'hACE1;
  localparam logic [15:0] RAND_TAPS = 16'hB400;
  localparam logic [2:0] CFG_SPARE = 3'd4;
  localparam int EDGE_ROWS_FROM = 5;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  typedef struct packed {
    cmd_t c;
    logic typed;
    res_t want;
  } dir_row_t;

  typedef struct packed {
    logic [1:0]  dir;
    logic [3:0]  span;
    logic [19:0] period;
    logic        retrig;
    int          items;
    int          learn_pct;
    int          clear_pct;
    int          restart_pct;
    int          s_lo;
    int          s_hi;
  } phase_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [2:0]    cfg_index = CFG_DIRECTION;
  logic [CFG_W-1:0] cfg_data = '0;
  logic          cmd_valid = 1'b0;
  logic          cmd_stall;
  cmd_t          cmd = '0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  res_t          res;

  // sequencer copy
  logic [7:0]  pat_mem [PATTERN_DEPTH];
  int          pat_len;
  logic [6:0]  ref_key;
  int          period_cnt;
  int          step_pos;
  int          oct_idx;
  logic        going_down;
  logic [15:0] lfsr;
  logic [1:0]  dir_cfg;
  logic [3:0]  span_cfg;
  logic [19:0] period_cfg;
  logic        retrig_cfg;

  res_t        pending_notes [$];
  int          errors = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  logic [7:0]  stall_cyc = '0;

  // first rows typed from the power-up state, the rest go through the predictor
  dir_row_t directed_rows [20] = '{
    '{'{OP_RESTART, 12'd0,    7'd0},   1'b1, '{7'd12,  1'b0, 7'd0, 4'd1}},
    '{'{OP_LEARN,   12'd0,    7'd127}, 1'b1, '{7'd127, 1'b0, 7'd0, 4'd1}},
    '{'{OP_TICK,    12'd4095, 7'd127}, 1'b1, '{7'd127, 1'b0, 7'd0, 4'd1}},
    '{'{OP_CLEAR,   12'd0,    7'd0},   1'b1, '{7'd12,  1'b0, 7'd0, 4'd1}},
    '{'{OP_TICK,    12'd4095, 7'd0},   1'b1, '{7'd12,  1'b0, 7'd0, 4'd1}},
    '{'{OP_TICK,    12'd0,    7'd60},  1'b0, '0},
    '{'{OP_LEARN,   12'd0,    7'd60},  1'b0, '0},
    '{'{OP_LEARN,   12'd4095, 7'd0},   1'b0, '0},
    '{'{OP_LEARN,   12'd0,    7'd127}, 1'b0, '0},
    '{'{OP_LEARN,   12'd0,    7'd72},  1'b0, '0},
    '{'{OP_RESTART, 12'd0,    7'd50},  1'b0, '0},
    '{'{OP_TICK,    12'd4095, 7'd0},   1'b0, '0},
    '{'{OP_TICK,    12'd4095, 7'd0},   1'b0, '0},
    '{'{OP_TICK,    12'd0,    7'd127}, 1'b0, '0},
    '{'{OP_TICK,    12'd1,    7'd3},   1'b0, '0},
    '{'{OP_CLEAR,   12'd4095, 7'd127}, 1'b0, '0},
    '{'{OP_TICK,    12'd2048, 7'd127}, 1'b0, '0},
    '{'{OP_LEARN,   12'd0,    7'd1},   1'b0, '0},
    '{'{OP_RESTART, 12'd0,    7'd126}, 1'b0, '0},
    '{'{OP_TICK,    12'd4095, 7'd126}, 1'b0, '0}
  };

  phase_t phases [7] = '{
    '{DIR_UPDOWN, 4'd3, 20'd5000,  1'b1, 110, 15, 4, 6, 0, 4095},
    '{DIR_UP,     4'd8, 20'd1,     1'b0, 90,  15, 4, 6, 0, 4095},
    '{DIR_DOWN,   4'd5, 20'd2000,  1'b1, 90,  15, 4, 6, 0, 4095},
    '{DIR_RANDOM, 4'd8, 20'd3000,  1'b1, 150, 12, 3, 6, 0, 4095},
    // learn-heavy with no clears: pattern runs full
    '{DIR_UP,     4'd2, 20'd2500,  1'b1, 150, 50, 0, 5, 0, 4095},
    // zero period, big ticks, no restart: counter sinks to its floor
    '{DIR_UPDOWN, 4'd4, 20'd0,     1'b1, 620, 6,  1, 0, 3900, 4095},
    '{DIR_RANDOM, 4'd0, 20'hFFFFF, 1'b0, 60,  15, 4, 10, 0, 4095}
  };

  note_step_sequencer_top i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int eff_span();
    return (span_cfg == 4'd0) ? 1 : int'(span_cfg);
  endfunction

  function automatic int last_step();
    return (pat_len != 0) ? pat_len - 1 : 0;
  endfunction

  function automatic logic [15:0] lfsr_shift(input logic [15:0] v);
    return {1'b0, v[15:1]} ^ (v[0] ? RAND_TAPS : 16'h0000);
  endfunction

  function automatic void advance_step();
    int span_e;
    span_e = eff_span();
    case (dir_cfg)
      DIR_UP: begin
        if (step_pos + 1 >= pat_len) begin
          step_pos = 0;
          oct_idx = (oct_idx + 1 > span_e) ? 1 : oct_idx + 1;
        end else begin
          step_pos++;
        end
      end
      DIR_DOWN: begin
        if (step_pos == 0) begin
          step_pos = last_step();
          oct_idx = (oct_idx <= 1) ? span_e : oct_idx - 1;
        end else begin
          step_pos--;
        end
      end
      DIR_UPDOWN: begin
        if (going_down) begin
          if (step_pos == 0) begin
            if (oct_idx <= 1) begin
              going_down = 1'b0;
              oct_idx = 1;
            end else begin
              oct_idx--;
              step_pos = last_step();
            end
          end else begin
            step_pos--;
          end
        end else if (step_pos + 1 >= pat_len) begin
          if (oct_idx + 1 > span_e) begin
            step_pos = last_step();
            going_down = 1'b1;
            oct_idx = span_e;
          end else begin
            oct_idx++;
            step_pos = 0;
          end
        end else begin
          step_pos++;
        end
      end
      default: begin
        lfsr = lfsr_shift(lfsr);
        step_pos = (pat_len != 0) ? int'(lfsr[7:0]) % pat_len : 0;
        lfsr = lfsr_shift(lfsr);
        oct_idx = int'(lfsr[1:0]) % span_e + 1;
      end
    endcase
  endfunction

  function automatic res_t sequence_note(input cmd_t c);
    int   cnt;
    int   off;
    int   k;
    logic trig;
    res_t r;
    trig = 1'b0;
    case (c.opcode)
      OP_TICK: begin
        cnt = period_cnt - int'(c.sample_count);
        if (cnt < COUNT_FLOOR) cnt = COUNT_FLOOR;
        if (cnt <= 0) begin
          cnt += int'(period_cfg);
          advance_step();
          trig = retrig_cfg;
        end
        period_cnt = cnt;
      end
      OP_LEARN: begin
        if (pat_len < PATTERN_DEPTH) begin
          if (pat_len == 0) ref_key = c.base_key;
          pat_mem[pat_len] = 8'(int'(c.base_key) - int'(ref_key));
          pat_len++;
        end
      end
      OP_CLEAR: begin
        pat_len = 0;
        step_pos = 0;
      end
      default: begin
        period_cnt = int'(period_cfg);
        if (dir_cfg == DIR_DOWN) begin
          step_pos = last_step();
          oct_idx = eff_span();
          going_down = 1'b1;
        end else begin
          step_pos = 0;
          oct_idx = 1;
          going_down = 1'b0;
        end
      end
    endcase
    off = (pat_len != 0) ? int'($signed(pat_mem[step_pos])) : 0;
    k = int'(c.base_key) + off + OCTAVE_KEYS * oct_idx;
    if (k < 0) k += OCTAVE_KEYS * ((-k + OCTAVE_KEYS - 1) / OCTAVE_KEYS);
    if (k >= KEY_RANGE) k -= OCTAVE_KEYS * ((k - KEY_RANGE) / OCTAVE_KEYS + 1);
    r.key_out = 7'(k);
    r.retrigger = trig;
    r.position = 7'(step_pos);
    r.octave_now = 4'(oct_idx);
    return r;
  endfunction

  task automatic reset_model();
    foreach (pat_mem[i]) pat_mem[i] = 8'd0;
    pat_mem[1] = 8'd4;
    pat_mem[2] = 8'd7;
    pat_mem[3] = 8'd12;
    pat_mem[4] = 8'd16;
    pat_len = 4;
    ref_key = 7'd0;
    period_cnt = 0;
    step_pos = 0;
    oct_idx = 1;
    going_down = 1'b0;
    lfsr = RAND_SEED;
    dir_cfg = DIR_UPDOWN;
    span_cfg = 4'd1;
    period_cfg = 20'd400000;
    retrig_cfg = 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // junk in the unused upper bits, then a write to a spare index that must not land
  task automatic program_regs(input logic [1:0] dir, input logic [3:0] span,
                              input logic [19:0] period, input logic retrig);
    write_reg(CFG_DIRECTION, {18'($urandom), dir});
    write_reg(CFG_OCTAVE_SPAN, {16'($urandom), span});
    write_reg(CFG_STEP_PERIOD, period);
    write_reg(CFG_RETRIGGER, {19'($urandom), retrig});
    write_reg(3'(CFG_SPARE + 3'($urandom_range(0, 3))), 20'($urandom));
    cfg_we <= 1'b0;
    dir_cfg = dir;
    span_cfg = span;
    period_cfg = period;
    retrig_cfg = retrig;
  endtask

  task automatic send_cmd(input cmd_t beat);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : $urandom_range(0, 3);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    cmd <= beat;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending_notes.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      stall_cyc <= stall_cyc + 8'd1;
      if (stall_cyc == 8'd0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE: res_stall <= 1'b0;
        STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
        default: res_stall <= (stall_cyc[2:0] < 3'd3);
      endcase
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_notes.size() == 0) begin
        $error("result beat with no note pending: %p", res);
        errors++;
      end else begin
        want = pending_notes.pop_front();
        if (res.key_out !== want.key_out) begin
          $error("key_out: expected %0d, got %0d", want.key_out, res.key_out);
          errors++;
        end
        if (res.retrigger !== want.retrigger) begin
          $error("retrigger: expected %0d, got %0d", want.retrigger, res.retrigger);
          errors++;
        end
        if (res.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, res.position);
          errors++;
        end
        if (res.octave_now !== want.octave_now) begin
          $error("octave_now: expected %0d, got %0d", want.octave_now, res.octave_now);
          errors++;
        end
      end
    end
  end

  initial begin
    int   r;
    cmd_t c;
    res_t note;
    reset_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(directed_rows); i++) begin
      if (i == EDGE_ROWS_FROM) begin
        wait_idle();
        // down, zero span, zero period: every tick steps once the counter is no longer positive
        program_regs(DIR_DOWN, 4'd0, 20'd0, 1'b1);
      end
      send_cmd(directed_rows[i].c);
      note = sequence_note(directed_rows[i].c);
      pending_notes.push_back(directed_rows[i].typed ? directed_rows[i].want : note);
    end

    foreach (phases[p]) begin
      wait_idle();
      program_regs(phases[p].dir, phases[p].span, phases[p].period, phases[p].retrig);
      for (int n = 0; n < phases[p].items; n++) begin
        r = $urandom_range(0, 99);
        if (r < phases[p].learn_pct) c.opcode = OP_LEARN;
        else if (r < phases[p].learn_pct + phases[p].clear_pct) c.opcode = OP_CLEAR;
        else if (r < phases[p].learn_pct + phases[p].clear_pct + phases[p].restart_pct)
          c.opcode = OP_RESTART;
        else c.opcode = OP_TICK;
        c.sample_count = 12'($urandom_range(phases[p].s_lo, phases[p].s_hi));
        c.base_key = 7'($urandom_range(0, 127));
        send_cmd(c);
        pending_notes.push_back(sequence_note(c));
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
